// ===== rtl/sparse_tap_convolution_reverb_assert.svh =====
// Assertion macros for the reverb RTL.
`ifndef SPARSE_TAP_CONVOLUTION_REVERB_ASSERT_SVH
`define SPARSE_TAP_CONVOLUTION_REVERB_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("reverb check failed");

// Next-cycle implication, checked outside reset.
`define STCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("reverb check failed");

`endif

// ===== rtl/stcr_pkg.sv =====
package stcr_pkg;

  // Delay line geometry; the depth is a power of two so addresses wrap by truncation.
  localparam int unsigned LINE_AW     = 19;
  localparam int unsigned DELAY_DEPTH = 1 << LINE_AW;
  localparam int unsigned LINE_W      = 24;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_TAPS_DEF = 2048;
  localparam int unsigned ACC_W       = 52;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TAP_COUNT     = 3'd0;
  localparam logic [2:0] CFG_DAMP_COEFF    = 3'd1;
  localparam logic [2:0] CFG_FEEDBACK_GAIN = 3'd2;
  localparam logic [2:0] CFG_LEVEL_LEFT    = 3'd3;
  localparam logic [2:0] CFG_LEVEL_RIGHT   = 3'd4;
  localparam logic [2:0] CFG_REVERSE_MODE  = 3'd5;
  localparam logic [2:0] CFG_ROOM_OFFSET   = 3'd6;

  // Request kinds.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TAP    = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [10:0]        tap_slot;
    logic [18:0]        tap_delay;
    logic [14:0]        tap_gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } out_item_t;

  typedef struct packed {
    logic [18:0] delay;
    logic [14:0] gain;
  } tap_entry_t;

  // One write request to the delay line.
  typedef struct packed {
    logic                     en;
    logic [LINE_AW-1:0]       addr;
    logic signed [LINE_W-1:0] data;
  } line_wr_t;

  // Saturate to a delay-line word.
  function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(25'sd8388607));
    lo = ACC_W'(signed'(-25'sd8388608));
    if (x > hi) begin
      return LINE_W'(hi);
    end else if (x < lo) begin
      return LINE_W'(lo);
    end
    return LINE_W'(x);
  endfunction

  // Saturate to an output sample.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    lo = -hi - ACC_W'(1);
    if (x > hi) begin
      return SAMPLE_BITS'(hi);
    end else if (x < lo) begin
      return SAMPLE_BITS'(lo);
    end
    return SAMPLE_BITS'(x);
  endfunction

endpackage

// ===== rtl/stcr_tap_ram.sv =====
module stcr_tap_ram #(
  parameter int unsigned MAX_TAPS = stcr_pkg::MAX_TAPS_DEF,
  localparam int unsigned TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [TAW-1:0]       waddr_i,
  input  stcr_pkg::tap_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [TAW-1:0]       raddr_i,
  output stcr_pkg::tap_entry_t rdata_o
);

  stcr_pkg::tap_entry_t mem [MAX_TAPS];
  stcr_pkg::tap_entry_t rdata_q;

  // Tap table storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stcr_line_ram.sv =====
module stcr_line_ram (
  input  logic                                      clk_i,
  input  stcr_pkg::line_wr_t                        wr_i,
  input  logic                                      re_i,
  input  logic [stcr_pkg::LINE_AW-1:0]              raddr_i,
  output logic signed [stcr_pkg::LINE_W-1:0]        rdata_o
);

  logic signed [stcr_pkg::LINE_W-1:0] mem [stcr_pkg::DELAY_DEPTH];
  logic signed [stcr_pkg::LINE_W-1:0] rdata_q;

  // Delay line storage: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sparse_tap_convolution_reverb.sv =====
// Sparse multi-tap delay reverb. After reset the block first zeroes its delay line,
// one word per cycle; no item is accepted until then, while configuration writes are
// taken at any time. A tap-load item is written to the tap table as it is accepted. A
// sample item passes through the damping steps, the tap loop over tap_count taps
// (tap_count clamped to the table size), the sum, the scaling and the feedback step:
// the taps are fetched and multiplied one per cycle, limited by the single read port of
// the delay-line memory, and the sample is followed by a read-modify-write of the
// feedback word. The last step stalls while the previous result still waits in the
// output register. One item is in work at a time; a finished result waits in an output
// register while the next item is taken.
`include "sparse_tap_convolution_reverb_assert.svh"

module sparse_tap_convolution_reverb #(
  parameter int unsigned MAX_TAPS = stcr_pkg::MAX_TAPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stcr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stcr_pkg::out_item_t out_item_o
);

  localparam int unsigned TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned SW  = (TAW > 11) ? TAW : 11;
  localparam int unsigned AW  = stcr_pkg::ACC_W;
  localparam int unsigned LW  = stcr_pkg::LINE_W;
  localparam int unsigned PW  = stcr_pkg::LINE_AW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_DAMP, S_LOOP, S_SUM, S_SCALE, S_FB
  } state_e;

  // Configuration registers.
  logic [11:0]        tap_count_q;
  logic [15:0]        damp_q;
  logic signed [14:0] fb_gain_q;
  logic [15:0]        lvl_l_q;
  logic [15:0]        lvl_r_q;
  logic               reverse_q;
  logic [14:0]        room_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= '0;
      damp_q      <= 16'd34610;
      fb_gain_q   <= '0;
      lvl_l_q     <= 16'd2048;
      lvl_r_q     <= 16'd2048;
      reverse_q   <= 1'b0;
      room_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stcr_pkg::CFG_TAP_COUNT:     tap_count_q <= cfg_data_i[11:0];
        stcr_pkg::CFG_DAMP_COEFF:    damp_q      <= cfg_data_i;
        stcr_pkg::CFG_FEEDBACK_GAIN: fb_gain_q   <= cfg_data_i[14:0];
        stcr_pkg::CFG_LEVEL_LEFT:    lvl_l_q     <= cfg_data_i;
        stcr_pkg::CFG_LEVEL_RIGHT:   lvl_r_q     <= cfg_data_i;
        stcr_pkg::CFG_REVERSE_MODE:  reverse_q   <= cfg_data_i[0];
        stcr_pkg::CFG_ROOM_OFFSET:   room_q      <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  state_e                    state_q;
  logic [PW-1:0]             clr_q;
  logic [PW-1:0]             ptr_q;
  logic signed [LW-1:0]      damped_q;
  logic signed [15:0]        left_q;
  logic signed [15:0]        mono_q;
  logic signed [41:0]        mix_q;
  logic [12:0]               j_q;
  logic [12:0]               n_q;
  logic                      v1_q, v2_q, v3_q;
  logic [14:0]               gain_q;
  logic signed [38:0]        prod_q;
  logic signed [AW-1:0]      acc_q;
  logic signed [LW-1:0]      sum_q;
  logic signed [40:0]        pl_q, pr_q;
  logic signed [38:0]        pf_q;
  logic [PW-1:0]             fb_addr_q;
  logic                      out_valid_q;
  stcr_pkg::out_item_t       out_q;

  stcr_pkg::tap_entry_t      tap_rd;
  logic signed [LW-1:0]      line_rd;
  stcr_pkg::line_wr_t        line_wr;
  logic                      line_re;
  logic [PW-1:0]             line_raddr;
  logic                      tap_we, tap_re, issue, fb_go;
  logic [SW-1:0]             slot_ext;
  logic signed [16:0]        lr_sum;
  logic [16:0]               h_inv;
  logic signed [AW-1:0]      mix_rnd;
  logic signed [LW-1:0]      damp_new;
  logic signed [LW-1:0]      line_in;
  logic signed [AW-1:0]      fb_val;
  logic [12:0]               n_next;

  // Input side handshake and tap table write.
  assign in_ready_o = (state_q == S_IDLE);
  assign slot_ext   = SW'(in_item_i.tap_slot);
  assign tap_we     = in_valid_i && in_ready_o && (in_item_i.req_type == stcr_pkg::REQ_TAP)
                      && (32'(in_item_i.tap_slot) < MAX_TAPS);
  assign issue      = (state_q == S_LOOP) && (j_q < n_q);
  assign tap_re     = issue;
  assign fb_go      = (state_q == S_FB) && (!out_valid_q || out_ready_i);

  // Number of summed taps, clamped to the table size.
  assign n_next = ({1'b0, tap_count_q} > 13'(MAX_TAPS)) ? 13'(MAX_TAPS) : {1'b0, tap_count_q};

  // Damping lowpass arithmetic.
  assign lr_sum   = 17'(in_item_i.sample_left) + 17'(in_item_i.sample_right);
  assign h_inv    = 17'h10000 - {1'b0, damp_q};
  assign mix_rnd  = (AW'(mix_q) + AW'(32768)) >>> 16;
  assign damp_new = stcr_pkg::sat_line(mix_rnd);
  assign line_in  = reverse_q ?
                    stcr_pkg::sat_line(AW'(damp_new >>> 1) - AW'(left_q)) : damp_new;
  assign fb_val   = (AW'(pf_q) + AW'(16384)) >>> 15;

  // Delay line read port: tap words during the loop, the feedback word afterwards.
  always_comb begin
    line_re    = 1'b0;
    line_raddr = ptr_q + tap_rd.delay;
    if (state_q == S_LOOP && v1_q) begin
      line_re = 1'b1;
    end else if (state_q == S_SCALE) begin
      line_re    = 1'b1;
      line_raddr = ptr_q + PW'(room_q);
    end
  end

  // Delay line write port: clearing pass, new sample, feedback update.
  always_comb begin
    line_wr = '0;
    unique case (state_q)
      S_CLEAR: begin
        line_wr.en   = 1'b1;
        line_wr.addr = clr_q;
      end
      S_DAMP: begin
        line_wr.en   = 1'b1;
        line_wr.addr = ptr_q;
        line_wr.data = line_in;
      end
      S_FB: begin
        line_wr.en   = fb_go;
        line_wr.addr = fb_addr_q;
        line_wr.data = stcr_pkg::sat_line(AW'(line_rd) + fb_val);
      end
      default: ;
    endcase
  end

  stcr_tap_ram #(.MAX_TAPS(MAX_TAPS)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (slot_ext[TAW-1:0]),
    .wdata_i ({in_item_i.tap_delay, in_item_i.tap_gain}),
    .re_i    (tap_re),
    .raddr_i (j_q[TAW-1:0]),
    .rdata_o (tap_rd)
  );

  stcr_line_ram u_line_ram (
    .clk_i   (clk_i),
    .wr_i    (line_wr),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rd)
  );

  // Sequencer with its datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ptr_q       <= '0;
      damped_q    <= '0;
      left_q      <= '0;
      mono_q      <= '0;
      mix_q       <= '0;
      j_q         <= '0;
      n_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      gain_q      <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      sum_q       <= '0;
      pl_q        <= '0;
      pr_q        <= '0;
      pf_q        <= '0;
      fb_addr_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // The result register fills on the last step and empties when taken.
      out_valid_q <= fb_go || (out_valid_q && !out_ready_i);
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i && in_item_i.req_type == stcr_pkg::REQ_SAMPLE) begin
            left_q  <= in_item_i.sample_left;
            mono_q  <= lr_sum[16:1];
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          mix_q   <= 42'(mono_q * $signed({1'b0, damp_q}));
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          mix_q   <= mix_q + 42'(damped_q * $signed({1'b0, h_inv}));
          state_q <= S_DAMP;
        end
        S_DAMP: begin
          damped_q <= line_in;
          acc_q    <= '0;
          j_q      <= '0;
          n_q      <= n_next;
          state_q  <= S_LOOP;
        end
        S_LOOP: begin
          if (issue) begin
            j_q <= j_q + 13'd1;
          end
          v1_q <= issue;
          v2_q <= v1_q;
          v3_q <= v2_q;
          if (v1_q) begin
            gain_q <= tap_rd.gain;
          end
          if (v2_q) begin
            prod_q <= 39'(line_rd * $signed({1'b0, gain_q}));
          end
          if (v3_q) begin
            acc_q <= acc_q + AW'(prod_q);
          end
          if (!issue && !v1_q && !v2_q && !v3_q) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          sum_q   <= stcr_pkg::sat_line((acc_q + AW'(16384)) >>> 15);
          ptr_q   <= ptr_q - PW'(1);
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          pl_q      <= 41'(sum_q * $signed({1'b0, lvl_l_q}));
          pr_q      <= 41'(sum_q * $signed({1'b0, lvl_r_q}));
          pf_q      <= 39'(sum_q * fb_gain_q);
          fb_addr_q <= line_raddr;
          state_q   <= S_FB;
        end
        S_FB: begin
          if (fb_go) begin
            out_q.out_left  <= stcr_pkg::sat_out((AW'(pl_q) + AW'(1024)) >>> 11);
            out_q.out_right <= stcr_pkg::sat_out((AW'(pr_q) + AW'(1024)) >>> 11);
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Tap fetches never run past the active tap count.
  `STCR_ASSERT_IMP(a_tap_bound, state_q == S_LOOP, j_q <= n_q)
  // The accumulator pipeline only runs inside the tap loop.
  `STCR_ASSERT_IMP(a_pipe_in_loop, v1_q || v2_q || v3_q, state_q == S_LOOP)
  // Finishing a sample always presents a result in the next cycle.
  `STCR_ASSERT_NXT(a_result_out, fb_go, out_valid_o && state_q == S_IDLE)

endmodule

// ===== verif/tb_sparse_tap_convolution_reverb.sv =====
module tb_sparse_tap_convolution_reverb;

  localparam int unsigned TAP_SLOTS   = 2048;
  localparam longint      LINE_HI     = 64'sd8388607;
  localparam longint      LINE_LO     = -64'sd8388608;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  // Tracks the reverb state and the queue of outputs still owed by the block.
  class reverb_scoreboard;
    int                  line_mem [stcr_pkg::DELAY_DEPTH];
    logic [18:0]         tap_dly  [TAP_SLOTS];
    logic [14:0]         tap_gn   [TAP_SLOTS];
    logic [18:0]         wr_ptr;
    longint              damp_state;
    int unsigned         n_taps;
    int unsigned         damp_h;
    longint              fb_gain;
    int unsigned         lvl_l;
    int unsigned         lvl_r;
    bit                  rev_on;
    int unsigned         room_ofs;
    stcr_pkg::out_item_t owed_outs[$];
    int                  errors;

    function new();
      wr_ptr     = '0;
      damp_state = 0;
      n_taps     = 0;
      damp_h     = 34610;
      fb_gain    = 0;
      lvl_l      = 2048;
      lvl_r      = 2048;
      rev_on     = 1'b0;
      room_ofs   = 0;
      errors     = 0;
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        stcr_pkg::CFG_TAP_COUNT:     n_taps   = data[11:0];
        stcr_pkg::CFG_DAMP_COEFF:    damp_h   = data;
        stcr_pkg::CFG_FEEDBACK_GAIN: fb_gain  = longint'($signed(data[14:0]));
        stcr_pkg::CFG_LEVEL_LEFT:    lvl_l    = data;
        stcr_pkg::CFG_LEVEL_RIGHT:   lvl_r    = data;
        stcr_pkg::CFG_REVERSE_MODE:  rev_on   = data[0];
        stcr_pkg::CFG_ROOM_OFFSET:   room_ofs = data[14:0];
        default: ;
      endcase
    endfunction

    // Tap loads update the table; each sample item produces one stereo output.
    function void note_input(stcr_pkg::in_item_t it);
      longint              lft, rgt, mono, acc, sum, fb;
      int unsigned         taps, addr;
      stcr_pkg::out_item_t res;
      if (it.req_type == stcr_pkg::REQ_TAP) begin
        tap_dly[it.tap_slot] = it.tap_delay;
        tap_gn[it.tap_slot]  = it.tap_gain;
        return;
      end
      lft  = longint'(it.sample_left);
      rgt  = longint'(it.sample_right);
      mono = (lft + rgt) >>> 1;
      damp_state = (mono * longint'(damp_h) + damp_state * longint'(65536 - damp_h)
                    + 32768) >>> 16;
      damp_state = clip(damp_state, LINE_LO, LINE_HI);
      if (rev_on) begin
        damp_state = clip((damp_state >>> 1) - lft, LINE_LO, LINE_HI);
      end
      line_mem[wr_ptr] = int'(damp_state);
      taps = (n_taps > TAP_SLOTS) ? TAP_SLOTS : n_taps;
      acc  = 0;
      for (int j = 0; j < taps; j++) begin
        addr = (wr_ptr + tap_dly[j]) % stcr_pkg::DELAY_DEPTH;
        acc += longint'(line_mem[addr]) * longint'(tap_gn[j]);
      end
      sum = clip((acc + 16384) >>> 15, LINE_LO, LINE_HI);
      res.out_left  = 16'(clip((sum * longint'(lvl_l) + 1024) >>> 11, -32768, 32767));
      res.out_right = 16'(clip((sum * longint'(lvl_r) + 1024) >>> 11, -32768, 32767));
      owed_outs.push_back(res);
      wr_ptr = wr_ptr - 1'b1;
      fb     = (sum * fb_gain + 16384) >>> 15;
      addr   = (wr_ptr + room_ofs) % stcr_pkg::DELAY_DEPTH;
      line_mem[addr] = int'(clip(longint'(line_mem[addr]) + fb, LINE_LO, LINE_HI));
    endfunction

    function void check_output(stcr_pkg::out_item_t got);
      stcr_pkg::out_item_t want;
      if (owed_outs.size() == 0) begin
        $error("unexpected output item %h", got);
        errors++;
        return;
      end
      want = owed_outs.pop_front();
      if (got.out_left !== want.out_left) begin
        $error("out_left: expected %0d, got %0d", want.out_left, got.out_left);
        errors++;
      end
      if (got.out_right !== want.out_right) begin
        $error("out_right: expected %0d, got %0d", want.out_right, got.out_right);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [2:0]          cfg_idx_i;
  logic [15:0]         cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  stcr_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  stcr_pkg::out_item_t out_item_o;

  reverb_scoreboard sb;
  bit          slot_loaded[TAP_SLOTS];
  int unsigned cycle_count;
  int unsigned tap_prefix;

  sparse_tap_convolution_reverb DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Accepted items on both channels feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_input(in_item_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_output(out_item_o);
    end
  end

  // The receiver cycles through always-ready, random and long-stall stretches.
  always @(negedge clk_i) begin
    case ((cycle_count / 300) % 3)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(1, 0) == 1);
      default: out_ready_i <= ($urandom_range(5, 0) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(stcr_pkg::in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_sender(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic load_tap(int unsigned slot, int unsigned dly, int unsigned gn);
    stcr_pkg::in_item_t it;
    it           = '0;
    it.req_type  = stcr_pkg::REQ_TAP;
    it.tap_slot  = 11'(slot);
    it.tap_delay = 19'(dly);
    it.tap_gain  = 15'(gn);
    slot_loaded[slot] = 1'b1;
    while (tap_prefix < TAP_SLOTS && slot_loaded[tap_prefix]) tap_prefix++;
    send_item(it);
  endtask

  task automatic send_sample(int lft, int rgt);
    stcr_pkg::in_item_t it;
    it              = stcr_pkg::in_item_t'($urandom());
    it.req_type     = stcr_pkg::REQ_SAMPLE;
    it.sample_left  = 16'(lft);
    it.sample_right = 16'(rgt);
    send_item(it);
  endtask

  // Registers change only with no item in flight.
  task automatic drain();
    idle_sender(1);
    while (sb.owed_outs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_regs(int unsigned taps, int unsigned damp, int fbg, int unsigned ll,
                            int unsigned lr, bit rev, int unsigned room);
    logic [15:0] vals[7];
    vals = '{16'(taps), 16'(damp), {1'b0, 15'(fbg)}, 16'(ll), 16'(lr), 16'(rev), 16'(room)};
    for (int i = 0; i < 7; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= vals[i];
      sb.write_reg(3'(i), vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_sample();
    case ($urandom_range(3, 0))
      0: return int'($urandom_range(65535, 0)) - 32768;
      1: return int'($urandom_range(2000, 0)) - 1000;
      2: return $urandom_range(1, 0) ? 32767 : -32768;
      default: return int'($urandom_range(16000, 0)) - 8000;
    endcase
  endfunction

  function automatic int unsigned pick_delay();
    case ($urandom_range(2, 0))
      0: return $urandom_range(524287, 0);
      1: return $urandom_range(64, 0);
      default: return $urandom_range(3000, 0);
    endcase
  endfunction

  // One phase of random traffic, sent in bursts separated by random gaps.
  task automatic random_items(int unsigned count);
    int unsigned burst;
    int unsigned slot;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(8, 1);
        if ($urandom_range(2, 0) != 0) idle_sender($urandom_range(6, 0));
      end
      burst--;
      if ($urandom_range(9, 0) < 7) begin
        send_sample(pick_sample(), pick_sample());
      end else begin
        slot = ($urandom_range(1, 0) == 1) ? $urandom_range(2047, 0)
                                           : $urandom_range(tap_prefix + 3, 0) % TAP_SLOTS;
        load_tap(slot, pick_delay(), $urandom_range(32767, 0));
      end
    end
  endtask

  initial begin
    int unsigned taps;
    sb          = new();
    cycle_count = 0;
    tap_prefix  = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = stcr_pkg::CFG_TAP_COUNT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: sample extremes with no taps, then tap extremes.
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(32767, -32768);
    send_sample(0, 0);
    load_tap(0, 0, 32767);
    load_tap(1, 524287, 32767);
    load_tap(2, 1, 16384);
    load_tap(3, 2, 0);
    load_tap(2047, 524287, 0);
    drain();
    write_regs(4, 65535, 16383, 65535, 0, 1'b0, 32767);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(12345, -54);
    send_sample(-32768, 32767);
    drain();
    write_regs(4, 0, -16384, 0, 65535, 1'b1, 0);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(100, 300);
    send_sample(-32768, 32767);
    drain();

    // Random phases over a mix of ordinary and extreme settings.
    for (int ph = 0; ph < 7; ph++) begin
      taps = (ph % 3 == 0) ? tap_prefix : $urandom_range(tap_prefix, 0);
      if (taps > 48) taps = 48;
      write_regs(taps, (ph == 1) ? 0 : ((ph == 2) ? 65535 : $urandom_range(65535, 0)),
                 (ph == 3) ? -16384 : ((ph == 4) ? 16383 : int'($urandom_range(14745, 0)) - 9830),
                 (ph == 5) ? 65535 : $urandom_range(8192, 0),
                 (ph == 6) ? 0 : $urandom_range(65535, 0),
                 ph[0], (ph == 2) ? 32767 : $urandom_range(32767, 0));
      random_items(38);
      drain();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
